// ===== rtl/ppld_pkg.sv =====
package ppld_pkg;

  localparam int CHAN_COUNT = 8;
  localparam int CH_IDX_W   = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

  localparam logic [31:0] TAP_MASK    = 32'h8000_2001;
  localparam logic [6:0]  EARLY_LIMIT = 7'd94;
  localparam logic [6:0]  EARLY_SAT   = 7'd95;
  localparam logic [5:0]  PHASE_MAX   = 6'd63;

  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] sample_word;
    logic        block_start;
  } ppld_in_t;

  typedef struct packed {
    logic       locked;
    logic [5:0] phase;
    logic       lost_lock;
    logic       new_lock;
    logic       block_status;
  } ppld_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_STEP,
    ST_SEARCH,
    ST_FINISH
  } ppld_state_t;

  typedef struct packed {
    logic take;
    logic prep;
    logic step;
    logic search;
    logic commit;
  } ppld_cmd_t;

  typedef struct packed {
    logic search_needed;
    logic match;
    logic last_rot;
    logic out_free;
  } ppld_sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] k);
    logic [127:0] dbl;
    dbl = {v, v} << k;
    return dbl[127:64];
  endfunction

  // diff must be nonzero
  function automatic logic [5:0] lowest_one_index(input logic [63:0] d);
    logic [63:0] iso;
    logic [5:0]  r;
    iso = d & (~d + 64'd1);
    r = '0;
    for (int b = 0; b < 6; b++) begin
      for (int j = 0; j < 64; j++) begin
        if (j[b]) begin
          r[b] = r[b] | iso[j];
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/pilot_parity_lock_detector_unit.sv =====
// Pilot parity lock detector with one independent detector per channel.
// Input beats (in_valid / in_stall) carry a channel number, a 32-bit PCM
// word and a block-start mark; each beat yields exactly one result beat
// (out_valid / out_stall) with lock state, phase, lost/new lock flags and
// the channel's running block status.
// The pilot pattern is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle: the block itself does not enforce this.
// The rotation search runs only for an in-range channel that is neither locked nor skipping.
// The search compares one rotation of the pilot per cycle (64 at most);
// the next beat can be taken in the cycle after the result is registered,
// and no new beat is taken while one is still being worked on.
// The output register lets a new beat in while a result waits; a stalled
// result holds and the block waits to commit the next one until it goes.
// Synchronous reset clears all channel state, the pilot pattern and both
// channel handshakes.
module pilot_parity_lock_detector_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppld_pkg::ppld_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ppld_pkg::ppld_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data
);
  import ppld_pkg::*;

  ppld_cmd_t cmd;
  ppld_sts_t sts;

  ppld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppld_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/ppld_ctrl.sv =====
module ppld_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppld_pkg::ppld_sts_t sts,
  output ppld_pkg::ppld_cmd_t cmd
);
  import ppld_pkg::*;

  ppld_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: state_nxt = ST_STEP;
      ST_STEP: begin
        state_nxt = sts.search_needed ? ST_SEARCH : ST_FINISH;
      end
      ST_SEARCH: begin
        if (sts.match || sts.last_rot) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    cmd        = '0;
    cmd.take   = (state_r == ST_IDLE) && in_valid;
    cmd.prep   = (state_r == ST_PREP);
    cmd.step   = (state_r == ST_STEP);
    cmd.search = (state_r == ST_SEARCH);
    cmd.commit = (state_r == ST_FINISH) && sts.out_free;
  end

endmodule

// ===== rtl/ppld_dp.sv =====
module ppld_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ppld_pkg::ppld_in_t  in_data,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  ppld_pkg::ppld_cmd_t cmd,
  output ppld_pkg::ppld_sts_t sts,
  output logic                out_valid,
  input  logic                out_stall,
  output ppld_pkg::ppld_out_t out_data
);
  import ppld_pkg::*;

  // per-channel state
  logic [31:0] par_hist_r  [CHAN_COUNT];
  logic [63:0] chain_hist_r[CHAN_COUNT];
  logic        lock_flag_r [CHAN_COUNT];
  logic [5:0]  lock_phase_r[CHAN_COUNT];
  logic [5:0]  skip_cnt_r  [CHAN_COUNT];
  logic [6:0]  early_cnt_r [CHAN_COUNT];
  logic        status_bit_r[CHAN_COUNT];

  logic [63:0] pilot_r;

  // item and work registers
  logic [2:0]  ch_r;
  logic [31:0] word_r;
  logic        start_r;
  logic [31:0] par_r;
  logic [63:0] chain_r;
  logic        lock_r;
  logic [5:0]  phase_r;
  logic [5:0]  skip_r;
  logic [6:0]  early_r;
  logic        status_r;
  logic        lost_r;
  logic        found_r;
  logic [63:0] rot_r;
  logic [5:0]  idx_r;
  logic [5:0]  best_r;

  logic        out_valid_r;
  ppld_out_t   out_data_r;

  logic [CH_IDX_W-1:0] ci;
  logic [4:0]          ch_ext;
  logic                in_range;
  logic [31:0]         par_new;
  logic [63:0]         chain_new;
  logic [5:0]          ph_inc;
  logic [63:0]         diff;
  logic [5:0]          tz;
  logic [5:0]          best_nxt;
  logic [6:0]          early_inc;

  assign ci        = CH_IDX_W'(ch_r);
  assign ch_ext    = 5'(ch_r);
  assign in_range  = ch_ext < 5'(CHAN_COUNT);
  assign par_new   = {par_hist_r[ci][30:0], ^word_r};
  assign chain_new = {chain_hist_r[ci][62:0], ^(par_new & TAP_MASK)};
  assign ph_inc    = phase_r + 6'd1;
  assign diff      = chain_r ^ rot_r;
  assign tz        = lowest_one_index(diff);
  assign best_nxt  = (tz > best_r) ? tz : best_r;
  assign early_inc = (early_r < EARLY_SAT) ? early_r + 7'd1 : early_r;

  always_comb begin
    sts               = '0;
    sts.search_needed = in_range && !lock_r && (skip_r == '0);
    sts.match         = (diff == '0);
    sts.last_rot      = (idx_r == PHASE_MAX);
    sts.out_free      = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pilot_r <= '0;
    end else if (cfg_wr_en) begin
      pilot_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_r    <= in_data.channel;
      word_r  <= in_data.sample_word;
      start_r <= in_data.block_start;
    end

    if (cmd.prep) begin
      par_r    <= par_new;
      chain_r  <= chain_new;
      lock_r   <= lock_flag_r[ci];
      phase_r  <= lock_phase_r[ci];
      skip_r   <= skip_cnt_r[ci];
      early_r  <= early_cnt_r[ci];
      status_r <= start_r ? lock_flag_r[ci] : status_bit_r[ci];
      lost_r   <= 1'b0;
      found_r  <= 1'b0;
      rot_r    <= pilot_r;
      idx_r    <= '0;
      best_r   <= '0;
    end

    if (cmd.step && in_range) begin
      if (lock_r) begin
        phase_r <= ph_inc;
        if (chain_r != rotl64(pilot_r, ph_inc)) begin
          lock_r   <= 1'b0;
          status_r <= 1'b0;
          lost_r   <= 1'b1;
        end
      end else if (skip_r != '0) begin
        skip_r <= skip_r - 6'd1;
      end
    end

    if (cmd.search) begin
      if (diff == '0) begin
        lock_r  <= 1'b1;
        phase_r <= idx_r;
        found_r <= 1'b1;
        if (early_r <= EARLY_LIMIT) status_r <= 1'b1;
      end else begin
        best_r <= best_nxt;
        skip_r <= PHASE_MAX - best_nxt;
        rot_r  <= {rot_r[62:0], rot_r[63]};
        idx_r  <= idx_r + 6'd1;
      end
    end

    if (cmd.commit) begin
      if (in_range) begin
        out_data_r.locked       <= lock_r;
        out_data_r.phase        <= lock_r ? phase_r : 6'd0;
        out_data_r.lost_lock    <= lost_r;
        out_data_r.new_lock     <= found_r;
        out_data_r.block_status <= status_r;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
        par_hist_r[c]   <= '0;
        chain_hist_r[c] <= '0;
        lock_flag_r[c]  <= 1'b0;
        lock_phase_r[c] <= '0;
        skip_cnt_r[c]   <= '0;
        early_cnt_r[c]  <= '0;
        status_bit_r[c] <= 1'b0;
      end
    end else if (cmd.commit && in_range) begin
      par_hist_r[ci]   <= par_r;
      chain_hist_r[ci] <= chain_r;
      lock_flag_r[ci]  <= lock_r;
      lock_phase_r[ci] <= phase_r;
      skip_cnt_r[ci]   <= skip_r;
      early_cnt_r[ci]  <= early_inc;
      status_bit_r[ci] <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/pilot_parity_lock_detector_unit_tb.sv =====
`timescale 1ns / 100ps

module pilot_parity_lock_detector_unit_tb;
  import ppld_pkg::*;

  localparam int TIMEOUT_NS = 12_000_000;

  class pilot_lock_scoreboard;
    logic [63:0] pilot;
    logic [31:0] par_hist [CHAN_COUNT];
    logic [63:0] chain_hist [CHAN_COUNT];
    bit          lock_on [CHAN_COUNT];
    logic [5:0]  lock_ph [CHAN_COUNT];
    logic [5:0]  skip_left [CHAN_COUNT];
    logic [6:0]  seen [CHAN_COUNT];
    bit          status [CHAN_COUNT];
    ppld_out_t   status_q [$];
    int          errors;
    int          checked;
    int          locks;
    int          early_locks;
    int          unlocks;

    function new();
      pilot = '0;
      errors = 0;
      checked = 0;
      locks = 0;
      early_locks = 0;
      unlocks = 0;
      for (int c = 0; c < CHAN_COUNT; c++) begin
        par_hist[c] = '0;
        chain_hist[c] = '0;
        lock_on[c] = 1'b0;
        lock_ph[c] = '0;
        skip_left[c] = '0;
        seen[c] = '0;
        status[c] = 1'b0;
      end
    endfunction

    function logic [63:0] rotated(logic [5:0] k);
      if (k == 6'd0) return pilot;
      return (pilot << k) | (pilot >> (7'd64 - {1'b0, k}));
    endfunction

    function int low_zeros(logic [63:0] d);
      int n;
      n = 0;
      while (n < 63 && !d[n]) n++;
      return n;
    endfunction

    // advance one channel by one sample and queue the status it must report
    function void take_sample(ppld_in_t b);
      int c;
      int best;
      int tz;
      bit lost;
      bit found;
      logic [63:0] diff;
      ppld_out_t r;
      r = '0;
      if (int'(b.channel) >= CHAN_COUNT) begin
        status_q.push_back(r);
        return;
      end
      c = b.channel;
      lost = 1'b0;
      found = 1'b0;
      if (b.block_start) status[c] = lock_on[c];
      par_hist[c] = {par_hist[c][30:0], ^b.sample_word};
      chain_hist[c] = {chain_hist[c][62:0], ^(par_hist[c] & TAP_MASK)};
      if (lock_on[c]) begin
        lock_ph[c] = lock_ph[c] + 6'd1;
        if (chain_hist[c] != rotated(lock_ph[c])) begin
          lock_on[c] = 1'b0;
          status[c] = 1'b0;
          lost = 1'b1;
          unlocks++;
        end
      end else if (skip_left[c] == 6'd0) begin
        best = 0;
        for (int i = 0; i < 64; i++) begin
          diff = chain_hist[c] ^ rotated(6'(i));
          if (diff == '0) begin
            if (seen[c] <= EARLY_LIMIT) begin
              status[c] = 1'b1;
              early_locks++;
            end
            lock_on[c] = 1'b1;
            lock_ph[c] = 6'(i);
            found = 1'b1;
            locks++;
            break;
          end
          tz = low_zeros(diff);
          if (tz > best) best = tz;
          // retained even when a later rotation matches
          skip_left[c] = 6'(63 - best);
        end
      end else begin
        skip_left[c] = skip_left[c] - 6'd1;
      end
      if (seen[c] < EARLY_SAT) seen[c] = seen[c] + 7'd1;
      r.locked = lock_on[c];
      r.phase = lock_on[c] ? lock_ph[c] : 6'd0;
      r.lost_lock = lost;
      r.new_lock = found;
      r.block_status = status[c];
      status_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task check_status(ppld_out_t got);
      ppld_out_t want;
      if (status_q.size() == 0) begin
        report($sformatf("result %h with none pending", got));
        return;
      end
      want = status_q.pop_front();
      checked++;
      if (got.locked !== want.locked)
        report($sformatf("locked %b, want %b", got.locked, want.locked));
      if (got.phase !== want.phase)
        report($sformatf("phase %0d, want %0d", got.phase, want.phase));
      if (got.lost_lock !== want.lost_lock)
        report($sformatf("lost_lock %b, want %b", got.lost_lock, want.lost_lock));
      if (got.new_lock !== want.new_lock)
        report($sformatf("new_lock %b, want %b", got.new_lock, want.new_lock));
      if (got.block_status !== want.block_status)
        report($sformatf("block_status %b, want %b", got.block_status, want.block_status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ppld_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ppld_out_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  pilot_lock_scoreboard sb = new();

  int         beats = 0;
  int         pilot_writes = 0;
  int         burst_left = 0;
  int         stall_tick = 0;
  logic [1:0] stall_mode = 2'd0;

  pilot_parity_lock_detector_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 400 == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ((stall_tick % 5) < 2);
      default: out_stall <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_status(out_data);
  end

  task automatic send_beat(input logic [2:0] ch, input logic [31:0] word, input bit bs);
    ppld_in_t b;
    b.channel = ch;
    b.sample_word = word;
    b.block_start = bs;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    sb.take_sample(b);
    beats++;
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pilot(input logic [63:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.pilot = v;
    pilot_writes++;
  endtask

  // pick a word whose parity drives the channel's chain history to the wanted bit
  function automatic logic [31:0] word_for_bit(int ch, bit want);
    logic [31:0] w;
    bit p;
    int k;
    p = want ^ sb.par_hist[ch][12] ^ sb.par_hist[ch][30];
    w = $urandom;
    k = $urandom_range(0, 31);
    if (^w != p) w[k] = ~w[k];
    return w;
  endfunction

  task automatic run_phase(input logic [63:0] v, input int n, input int focus, input int second);
    int k [CHAN_COUNT];
    int ch;
    int pick;
    bit want;
    logic [31:0] w;
    logic [63:0] rot_v;
    write_pilot(v);
    for (int c = 0; c < CHAN_COUNT; c++) k[c] = $urandom_range(0, 63);
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) ch = focus;
      else if (pick < 88) ch = second;
      else ch = $urandom_range(0, CHAN_COUNT - 1);
      if (pick < 88) begin
        rot_v = sb.rotated(6'(k[ch]));
        want = rot_v[63];
        k[ch] = (k[ch] + 1) % 64;
        if (sb.lock_on[ch] && $urandom_range(0, 39) == 0) want = ~want;
        w = word_for_bit(ch, want);
      end else begin
        case ($urandom_range(0, 3))
          0: w = '0;
          1: w = '1;
          default: w = $urandom;
        endcase
      end
      if (j == n / 2) drain();
      pace();
      send_beat(3'(ch), w, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    int focus;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pilot still at its reset value of zero
    pace(); send_beat(3'd0, 32'h0000_0000, 1'b1);
    pace(); send_beat(3'd0, 32'hffff_ffff, 1'b1);
    pace(); send_beat(3'd0, 32'h0000_0003, 1'b0);
    pace(); send_beat(3'd0, 32'h0000_0001, 1'b0);
    pace(); send_beat(3'd0, 32'h0000_0000, 1'b1);
    pace(); send_beat(3'd7, 32'h8000_0000, 1'b1);
    pace(); send_beat(3'd7, 32'h7fff_ffff, 1'b0);
    pace(); send_beat(3'd7, 32'hffff_fffe, 1'b0);
    pace(); send_beat(3'd1, 32'h0000_0000, 1'b0);
    pace(); send_beat(3'd3, 32'hdead_beef, 1'b1);
    write_pilot(64'h0);
    pace(); send_beat(3'd1, 32'h8000_0001, 1'b0);
    pace(); send_beat(3'd1, 32'h0000_0000, 1'b1);
    write_pilot('1);
    pace(); send_beat(3'd1, 32'h0000_0001, 1'b1);
    pace(); send_beat(3'd0, 32'h5555_5555, 1'b0);

    run_phase('1, 180, 5, 6);
    focus = $urandom_range(0, 7);
    run_phase({$urandom, $urandom}, 180, focus, (focus + 1 + $urandom_range(0, 6)) % 8);
    focus = $urandom_range(0, 7);
    run_phase(64'haaaa_aaaa_aaaa_aaaa, 180, focus, (focus + 1 + $urandom_range(0, 6)) % 8);
    focus = $urandom_range(0, 7);
    run_phase({$urandom, $urandom}, 180, focus, (focus + 1 + $urandom_range(0, 6)) % 8);
    focus = $urandom_range(0, 7);
    run_phase(64'h0000_0000_0000_0001, 180, focus, (focus + 1 + $urandom_range(0, 6)) % 8);

    drain();
    repeat (80) @(posedge clk);
    $display("Sent %0d beats over %0d pilot writes, checked %0d results.",
             beats, pilot_writes, sb.checked);
    $display("Predicted %0d locks (%0d inside the opening window) and %0d unlocks.",
             sb.locks, sb.early_locks, sb.unlocks);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
